[design/text_console_writer_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the text console writer
// Shared concurrent check forms; every user has clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tcw_pkg.sv]
// ---------------------------------------------------------------------------
// tcw_pkg
// Types, codes and constants shared by the text console writer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int DEF_NUM_COLUMNS = 80;
  localparam int DEF_NUM_ROWS    = 25;

  localparam logic [7:0] RESET_ATTR   = 8'd23;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam int CFG_IDX_W = 2;
  localparam int CELL_W    = 16;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } tcw_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_ATTR  = 2'd0,
    REG_CLEAR_ATTR = 2'd1
  } tcw_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } tcw_state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
    logic [7:0] read_char;
    logic [7:0] read_attr;
  } tcw_out_t;

  typedef struct packed {
    logic in_ready;
    logic res_load;
  } tcw_seq_ctl_t;

endpackage

[design/tcw_ram.sv]
// ---------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/tcw_seq.sv]
// ---------------------------------------------------------------------------
// tcw_seq
// Command sequencer: cursor, cell RAM access, scroll copy and fill sweeps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_writer_unit_macros.svh"

module tcw_seq import tcw_pkg::*; #(
  parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
  parameter int NUM_ROWS    = DEF_NUM_ROWS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_fire,
  input  tcw_in_t      item,
  input  logic         slot_free,
  input  logic [7:0]   text_attr,
  input  logic [7:0]   clear_attr,
  output tcw_seq_ctl_t ctl,
  output tcw_out_t     res
);

  localparam int NUM_CELLS = NUM_COLUMNS * NUM_ROWS;
  localparam int ADDR_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int COL_W     = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int ROW_W     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(NUM_COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(NUM_ROWS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(NUM_CELLS - 1);
  // first cell of the bottom row, also the number of cells moved by a scroll
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(NUM_CELLS - NUM_COLUMNS);

  tcw_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [CELL_W-1:0]   fill_val_r, fill_val_nxt;
  logic                rd_ok_r, rd_ok_nxt;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [CELL_W-1:0]   mem_rdata;

  logic                put_fire;
  logic                newline;
  logic                adv_line;
  logic                scroll;
  logic                rd_in_range;
  logic [ADDR_W-1:0]   put_addr;
  logic [ADDR_W-1:0]   copy_raddr;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NUM_CELLS),
    .ADDR_W(ADDR_W)
  ) u_cells (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign put_fire    = in_fire && (item.command == CMD_PUT);
  assign newline     = (item.char_code == NEWLINE_CODE);
  assign adv_line    = newline || (col_r == LAST_COL);
  assign scroll      = adv_line && (row_r == LAST_ROW);
  assign rd_in_range = (32'(item.cell_index) < NUM_CELLS);
  assign put_addr    = ADDR_W'(32'(row_r) * NUM_COLUMNS + 32'(col_r));
  assign copy_raddr  = ADDR_W'(32'(cnt_r) + NUM_COLUMNS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      cnt_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      fill_val_r <= {RESET_ATTR, 8'h00};
      rd_ok_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      fill_val_r <= fill_val_nxt;
      rd_ok_r    <= rd_ok_nxt;
    end
  end

  // next state, sweep counter and cursor
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    fill_val_nxt = fill_val_r;
    rd_ok_nxt    = rd_ok_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (item.command)
            CMD_PUT: begin
              if (adv_line) begin
                col_nxt = '0;
                if (scroll) begin
                  state_nxt    = ST_COPY;
                  cnt_nxt      = '0;
                  fill_val_nxt = {text_attr, 8'h00};
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
            CMD_CLEAR: begin
              state_nxt    = ST_FILL;
              cnt_nxt      = '0;
              fill_val_nxt = {clear_attr, 8'h00};
            end
            CMD_READ: begin
              state_nxt = ST_READ;
              rd_ok_nxt = rd_in_range;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        // counter ends on the bottom row start, where the fill begins
        if (cnt_r == COPY_END) begin
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FILL: begin
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // RAM port and result outputs
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = cnt_r;
    mem_wdata    = fill_val_r;
    mem_re       = 1'b0;
    mem_raddr    = copy_raddr;
    ctl.in_ready = (state_r == ST_IDLE) && slot_free;
    ctl.res_load = 1'b0;
    res.cursor_col = 7'(col_nxt);
    res.cursor_row = 5'(row_nxt);
    res.scrolled   = 1'b0;
    res.read_char  = '0;
    res.read_attr  = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (item.command)
            CMD_PUT: begin
              ctl.res_load = 1'b1;
              res.scrolled = scroll;
              if (!newline) begin
                mem_we    = 1'b1;
                mem_waddr = put_addr;
                mem_wdata = {text_attr, item.char_code};
              end
            end
            CMD_CLEAR: begin
              ctl.res_load = 1'b1;
            end
            CMD_READ: begin
              mem_re    = 1'b1;
              mem_raddr = ADDR_W'(item.cell_index);
            end
            default: ctl.res_load = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        ctl.res_load  = 1'b1;
        res.read_char = rd_ok_r ? mem_rdata[7:0] : 8'h00;
        res.read_attr = rd_ok_r ? mem_rdata[15:8] : 8'h00;
      end
      ST_COPY: begin
        // read one row ahead, write the cell read last cycle
        mem_re = (cnt_r != COPY_END);
        if (cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r - 1'b1;
          mem_wdata = mem_rdata;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  `TCW_ASSERT_IMPL(a_cursor_range, 1'b1, (32'(col_r) < NUM_COLUMNS) && (32'(row_r) < NUM_ROWS), "cursor outside the screen")
  `TCW_ASSERT_NEXT(a_read_wait, in_fire && (item.command == CMD_READ), state_r == ST_READ, "read did not wait for RAM data")
  `TCW_ASSERT_NEXT(a_scroll_copy, put_fire && scroll, state_r == ST_COPY, "scroll did not start the row copy")
  `TCW_ASSERT_IMPL(a_sweep_quiet, (state_r == ST_COPY) || (state_r == ST_FILL), !ctl.res_load && !ctl.in_ready, "beat taken or result loaded during a sweep")

endmodule

[design/text_console_writer_unit.sv]
// ---------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell text console: put, clear and read commands on a cell RAM.
// ---------------------------------------------------------------------------
//
//   channel   ports                               direction  beat
//   -------   ---------------------------------   ---------  ------------------
//   in        in_valid in_ready in_data           sink       one command
//   out       out_valid out_ready out_data        source     one result/command
//   cfg       cfg_valid cfg_ready cfg_index/wdata sink       one register write
//
// A put without scroll leaves the sequencer idle, so such beats stream at
// one per cycle while results drain; a read holds in_ready low while it
// waits for the registered RAM read. The single write port of the cell RAM
// sets the rest: a clear holds in_ready low while it fills every cell after
// its beat, a scroll while it copies the rows up (one cell a cycle) and then
// fills the bottom row. After reset every cell is cleared with in_ready low.
// The result register takes a new beat in the cycle the last result drains;
// a stalled result holds in_ready low. cfg_ready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_writer_unit_macros.svh"

module text_console_writer_unit import tcw_pkg::*; #(
  parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
  parameter int NUM_ROWS    = DEF_NUM_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcw_in_t              in_data,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcw_out_t             out_data,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  tcw_seq_ctl_t ctl;
  tcw_out_t     res;
  logic         in_fire;
  logic         slot_free;

  logic         out_valid_r, out_valid_nxt;
  tcw_out_t     out_data_r, out_data_nxt;
  logic [7:0]   text_attr_r, text_attr_nxt;
  logic [7:0]   clear_attr_r, clear_attr_nxt;

  // the result slot can take a new result when empty or draining this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = ctl.in_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tcw_seq #(
    .NUM_COLUMNS(NUM_COLUMNS),
    .NUM_ROWS   (NUM_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .item      (in_data),
    .slot_free (slot_free),
    .text_attr (text_attr_r),
    .clear_attr(clear_attr_r),
    .ctl       (ctl),
    .res       (res)
  );

  // register file: writes beyond the list drop silently
  always_comb begin
    text_attr_nxt  = text_attr_r;
    clear_attr_nxt = clear_attr_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEXT_ATTR:  text_attr_nxt  = cfg_wdata;
        REG_CLEAR_ATTR: clear_attr_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // result register: load a new beat, or drop the old one once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (ctl.res_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      text_attr_r  <= RESET_ATTR;
      clear_attr_r <= RESET_ATTR;
    end else begin
      out_valid_r  <= out_valid_nxt;
      text_attr_r  <= text_attr_nxt;
      clear_attr_r <= clear_attr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `TCW_ASSERT_IMPL(a_no_overwrite, ctl.res_load, !out_valid_r || out_ready, "result loaded over a pending beat")
  `TCW_ASSERT_IMPL(a_put_result, in_fire && (in_data.command != CMD_READ), ctl.res_load, "command beat gave no result")
  `TCW_ASSERT_NEXT(a_read_result, in_fire && (in_data.command == CMD_READ), ctl.res_load, "read beat gave no result")

endmodule
